>>> src/tlbpt_pkg.sv
// ----------------------------------------------------------------------------
// TLB page table translator package
// Shared state codes, command and status bundles, and fixed field widths.
// ----------------------------------------------------------------------------
package tlbpt_pkg;

  // Fixed widths of the stream fields.
  localparam int unsigned ADDR_W     = 16;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 120;

  // Bit positions of the result fields inside out_tdata.
  localparam int unsigned OUT_HIT_BIT   = 16;
  localparam int unsigned OUT_FAULT_BIT = 17;
  localparam int unsigned OUT_HTOT_LSB  = 18;
  localparam int unsigned OUT_MTOT_LSB  = 50;
  localparam int unsigned OUT_FTOT_LSB  = 82;
  localparam int unsigned OUT_USED_W    = 114;

  typedef enum logic [4:0] {
    ST_CLEAR   = 5'b00001,
    ST_IDLE    = 5'b00010,
    ST_PAGE    = 5'b00100,
    ST_LOOK    = 5'b01000,
    ST_RESOLVE = 5'b10000
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;   // write one invalid page table entry
    logic load;    // capture the address and start the page reduction
    logic calc;    // finish the page reduction
    logic look;    // compare TLB tags and read the page table
    logic commit;  // resolve, update state and load the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;  // the clearing pass is at its last entry
    logic out_full;    // the output register holds a result that is not taken
  } sts_t;

endpackage

>>> src/tlb_page_table_translator.sv
// ----------------------------------------------------------------------------
// TLB page table translator
// Translates virtual addresses through a FIFO-replaced TLB backed by a
// demand-paged page table, with saturating hit, miss and fault counts.
// ----------------------------------------------------------------------------
//
//  Channel | Ports                         | Payload
//  --------+-------------------------------+---------------------------------
//  input   | in_tvalid, in_tready, in_tdata | virtual address
//  result  | out_tvalid, out_tready,       | physical address, flags and
//          | out_tdata                     | running totals
//
// Each item passes the four controller steps in order: capture with the
// reciprocal multiply, page reduction, TLB compare with the page table read,
// and resolve with the write-back; a new address is taken only after resolve.
// After reset a clearing pass invalidates all PAGE_COUNT page table entries
// before the first transfer. A result not taken holds the next item in resolve.
// ----------------------------------------------------------------------------
module tlb_page_table_translator #(
  parameter int unsigned TLB_ENTRIES = 16,
  parameter int unsigned PAGE_COUNT  = 256,
  parameter int unsigned FRAME_COUNT = 256,
  parameter int unsigned OFFSET_BITS = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [15:0] virtual_address
  input  logic [tlbpt_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [15:0] physical_address, [16] tlb_hit, [17] page_fault,
  // [49:18] hit_total, [81:50] miss_total, [113:82] fault_total, rest zero
  output logic [tlbpt_pkg::OUT_DATA_W-1:0] out_tdata
);

  tlbpt_pkg::cmd_t cmd;
  tlbpt_pkg::sts_t sts;

  tlbpt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tlbpt_datapath #(
    .TLB_ENTRIES (TLB_ENTRIES),
    .PAGE_COUNT  (PAGE_COUNT),
    .FRAME_COUNT (FRAME_COUNT),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

>>> src/tlbpt_ctrl.sv
// ----------------------------------------------------------------------------
// TLB page table translator controller
// Sequences the clearing pass and the four steps of one translation.
// ----------------------------------------------------------------------------
module tlbpt_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  tlbpt_pkg::sts_t sts,
  output tlbpt_pkg::cmd_t cmd
);

  tlbpt_pkg::state_t state_r;
  tlbpt_pkg::state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tlbpt_pkg::ST_CLEAR: begin
        if (sts.clear_last) begin
          state_nxt = tlbpt_pkg::ST_IDLE;
        end
      end
      tlbpt_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = tlbpt_pkg::ST_PAGE;
        end
      end
      tlbpt_pkg::ST_PAGE: begin
        state_nxt = tlbpt_pkg::ST_LOOK;
      end
      tlbpt_pkg::ST_LOOK: begin
        state_nxt = tlbpt_pkg::ST_RESOLVE;
      end
      tlbpt_pkg::ST_RESOLVE: begin
        if (!sts.out_full) begin
          state_nxt = tlbpt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tlbpt_pkg::ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tlbpt_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready  = (state_r == tlbpt_pkg::ST_IDLE);
  assign cmd.clear  = (state_r == tlbpt_pkg::ST_CLEAR);
  assign cmd.load   = in_tready && in_tvalid;
  assign cmd.calc   = (state_r == tlbpt_pkg::ST_PAGE);
  assign cmd.look   = (state_r == tlbpt_pkg::ST_LOOK);
  // The state is only left once the output register can take the result.
  assign cmd.commit = (state_r == tlbpt_pkg::ST_RESOLVE) && !sts.out_full;

endmodule

>>> src/tlbpt_datapath.sv
// ----------------------------------------------------------------------------
// TLB page table translator datapath
// Page reduction, TLB tag store, page table memory, frame allocator,
// saturating counters and the output register.
// ----------------------------------------------------------------------------
module tlbpt_datapath #(
  parameter int unsigned TLB_ENTRIES = 16,
  parameter int unsigned PAGE_COUNT  = 256,
  parameter int unsigned FRAME_COUNT = 256,
  parameter int unsigned OFFSET_BITS = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  tlbpt_pkg::cmd_t                    cmd,
  output tlbpt_pkg::sts_t                    sts,
  input  logic [tlbpt_pkg::IN_DATA_W-1:0]    in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [tlbpt_pkg::OUT_DATA_W-1:0]   out_tdata
);

  localparam int unsigned TLB_W   = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
  localparam int unsigned FILL_W  = $clog2(TLB_ENTRIES + 1);
  localparam int unsigned PAGE_W  = $clog2(PAGE_COUNT);
  localparam int unsigned FRAME_W = $clog2(FRAME_COUNT);
  localparam int unsigned RAW_W   = (OFFSET_BITS >= tlbpt_pkg::ADDR_W) ? 1
                                    : tlbpt_pkg::ADDR_W - OFFSET_BITS;
  // Reduction modulo PAGE_COUNT by a floor reciprocal: the quotient estimate
  // is low by at most one, so a single compare and subtract corrects it.
  localparam int unsigned DIV_S   = RAW_W + PAGE_W;
  localparam int unsigned DIV_M   = (1 << DIV_S) / PAGE_COUNT;
  localparam int unsigned M_W     = RAW_W + 1;
  localparam int unsigned PROD_W  = RAW_W + M_W;
  localparam int unsigned REM_W   = RAW_W + PAGE_W + 1;
  localparam int unsigned PHYS_W  = FRAME_W + OFFSET_BITS;

  localparam logic [M_W-1:0]     RECIP      = M_W'(DIV_M);
  localparam logic [REM_W-1:0]   PAGES      = REM_W'(PAGE_COUNT);
  localparam logic [PAGE_W-1:0]  PAGE_LAST  = PAGE_W'(PAGE_COUNT - 1);
  localparam logic [FRAME_W-1:0] FRAME_LAST = FRAME_W'(FRAME_COUNT - 1);
  localparam logic [TLB_W-1:0]   SLOT_LAST  = TLB_W'(TLB_ENTRIES - 1);
  localparam logic [FILL_W-1:0]  FILL_FULL  = FILL_W'(TLB_ENTRIES);

  // Input capture and page reduction.
  logic [tlbpt_pkg::IN_DATA_W-1:0] va_r;
  logic [RAW_W-1:0]                raw_r;
  logic [PROD_W-1:0]               prod_r;
  logic [PAGE_W-1:0]               page_r;
  logic [RAW_W-1:0]                raw_in;
  logic [RAW_W-1:0]                quot;
  logic [REM_W-1:0]                rem;
  logic [REM_W-1:0]                rem_fix;
  logic [PAGE_W-1:0]               page_nxt;

  assign raw_in  = RAW_W'(in_tdata >> OFFSET_BITS);
  assign quot    = RAW_W'(prod_r >> DIV_S);
  assign rem     = REM_W'(raw_r) - REM_W'(REM_W'(quot) * PAGES);
  assign rem_fix = (rem >= PAGES) ? rem - PAGES : rem;
  assign page_nxt = PAGE_W'(rem_fix);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      va_r   <= in_tdata;
      raw_r  <= raw_in;
      prod_r <= PROD_W'(raw_in) * PROD_W'(RECIP);
    end
    if (cmd.calc) begin
      page_r <= page_nxt;
    end
  end

  // TLB: tags compared in parallel; only slots below the fill count count.
  logic [PAGE_W-1:0]      tag_r   [TLB_ENTRIES];
  logic [FRAME_W-1:0]     frame_r [TLB_ENTRIES];
  logic [TLB_ENTRIES-1:0] match_r;
  logic [TLB_ENTRIES-1:0] match_nxt;
  logic [FILL_W-1:0]      fill_r;
  logic [FILL_W-1:0]      fill_nxt;
  logic [TLB_W-1:0]       oldest_r;
  logic [TLB_W-1:0]       oldest_nxt;
  logic [TLB_W-1:0]       slot;
  logic [FRAME_W-1:0]     tlb_frame;
  logic                   hit;

  always_comb begin
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      match_nxt[i] = (FILL_W'(i) < fill_r) && (tag_r[i] == page_r);
    end
  end

  // A page sits in at most one valid slot, so the match vector is one-hot.
  always_comb begin
    tlb_frame = '0;
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      tlb_frame = tlb_frame | (match_r[i] ? frame_r[i] : '0);
    end
  end

  assign hit = |match_r;

  always_comb begin
    fill_nxt   = fill_r;
    oldest_nxt = oldest_r;
    if (fill_r < FILL_FULL) begin
      slot     = fill_r[TLB_W-1:0];
      fill_nxt = fill_r + FILL_W'(1);
    end else begin
      slot       = oldest_r;
      oldest_nxt = (oldest_r == SLOT_LAST) ? '0 : oldest_r + TLB_W'(1);
    end
  end

  // Page table memory: one entry holds a valid bit above the frame number.
  logic [FRAME_W:0]       pt_mem [PAGE_COUNT];
  logic [FRAME_W:0]       pt_rd_r;
  logic [PAGE_W-1:0]      clr_addr_r;
  logic [FRAME_W-1:0]     free_r;
  logic [FRAME_W-1:0]     free_nxt;
  logic                   fault;
  logic [FRAME_W-1:0]     frame_sel;
  logic                   pt_we;
  logic [PAGE_W-1:0]      pt_waddr;
  logic [FRAME_W:0]       pt_wdata;

  assign fault     = !hit && !pt_rd_r[FRAME_W];
  assign frame_sel = hit ? tlb_frame : (fault ? free_r : pt_rd_r[FRAME_W-1:0]);
  assign free_nxt  = (free_r == FRAME_LAST) ? '0 : free_r + FRAME_W'(1);

  assign pt_we    = cmd.clear || (cmd.commit && fault);
  assign pt_waddr = cmd.clear ? clr_addr_r : page_r;
  assign pt_wdata = cmd.clear ? '0 : {1'b1, free_r};

  always_ff @(posedge clk) begin
    if (pt_we) begin
      pt_mem[pt_waddr] <= pt_wdata;
    end
    if (cmd.look) begin
      pt_rd_r <= pt_mem[page_r];
      match_r <= match_nxt;
    end
    if (cmd.commit && !hit) begin
      tag_r[slot]   <= page_r;
      frame_r[slot] <= frame_sel;
    end
  end

  // Saturating counters and the output register.
  logic [tlbpt_pkg::CNT_W-1:0] hit_cnt_r;
  logic [tlbpt_pkg::CNT_W-1:0] miss_cnt_r;
  logic [tlbpt_pkg::CNT_W-1:0] fault_cnt_r;
  logic [tlbpt_pkg::CNT_W-1:0] hit_cnt_nxt;
  logic [tlbpt_pkg::CNT_W-1:0] miss_cnt_nxt;
  logic [tlbpt_pkg::CNT_W-1:0] fault_cnt_nxt;
  logic [PHYS_W-1:0]           phys_wide;
  logic                        out_valid_r;
  logic [tlbpt_pkg::OUT_DATA_W-1:0] out_data_r;

  always_comb begin
    hit_cnt_nxt   = hit_cnt_r;
    miss_cnt_nxt  = miss_cnt_r;
    fault_cnt_nxt = fault_cnt_r;
    if (hit) begin
      if (hit_cnt_r != '1) begin
        hit_cnt_nxt = hit_cnt_r + tlbpt_pkg::CNT_W'(1);
      end
    end else begin
      if (miss_cnt_r != '1) begin
        miss_cnt_nxt = miss_cnt_r + tlbpt_pkg::CNT_W'(1);
      end
      if (fault && (fault_cnt_r != '1)) begin
        fault_cnt_nxt = fault_cnt_r + tlbpt_pkg::CNT_W'(1);
      end
    end
  end

  assign phys_wide = {frame_sel, va_r[OFFSET_BITS-1:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r  <= '0;
      fill_r      <= '0;
      oldest_r    <= '0;
      free_r      <= '0;
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      fault_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clear) begin
        clr_addr_r <= clr_addr_r + PAGE_W'(1);
      end
      if (cmd.commit) begin
        hit_cnt_r   <= hit_cnt_nxt;
        miss_cnt_r  <= miss_cnt_nxt;
        fault_cnt_r <= fault_cnt_nxt;
        if (!hit) begin
          fill_r   <= fill_nxt;
          oldest_r <= oldest_nxt;
        end
        if (fault) begin
          free_r <= free_nxt;
        end
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data_r <= {
        (tlbpt_pkg::OUT_DATA_W - tlbpt_pkg::OUT_USED_W)'(0),
        fault_cnt_nxt,
        miss_cnt_nxt,
        hit_cnt_nxt,
        fault,
        hit,
        tlbpt_pkg::ADDR_W'(phys_wide)
      };
    end
  end

  assign sts.clear_last = (clr_addr_r == PAGE_LAST);
  assign sts.out_full   = out_valid_r && !out_tready;
  assign out_tvalid     = out_valid_r;
  assign out_tdata      = out_data_r;

endmodule

>>> sim/tlb_translation_checker.sv
// ----------------------------------------------------------------------------
// TLB translation checker
// Watches both stream channels of the translator and predicts each result
// from its own copy of the TLB, the page table and the running totals.
// Every result transfer is compared field by field with the oldest
// prediction.
// ----------------------------------------------------------------------------
module tlb_translation_checker #(
  parameter int unsigned TLB_ENTRIES = 16,
  parameter int unsigned PAGE_COUNT  = 256,
  parameter int unsigned FRAME_COUNT = 256,
  parameter int unsigned OFFSET_BITS = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  // [15:0] virtual_address
  input  logic [tlbpt_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  // [15:0] physical_address, [16] tlb_hit, [17] page_fault,
  // [49:18] hit_total, [81:50] miss_total, [113:82] fault_total, rest zero
  input  logic [tlbpt_pkg::OUT_DATA_W-1:0] out_tdata,
  output int unsigned                      mismatches,
  output int unsigned                      outstanding
);

  typedef struct {
    logic [tlbpt_pkg::ADDR_W-1:0] phys_addr;
    logic                         tlb_hit;
    logic                         page_fault;
    logic [tlbpt_pkg::CNT_W-1:0]  hit_total;
    logic [tlbpt_pkg::CNT_W-1:0]  miss_total;
    logic [tlbpt_pkg::CNT_W-1:0]  fault_total;
  } xlat_t;

  int unsigned                 tlb_page  [TLB_ENTRIES];
  int unsigned                 tlb_frame [TLB_ENTRIES];
  int unsigned                 tlb_used;
  int unsigned                 tlb_victim;
  bit                          pt_valid  [PAGE_COUNT];
  int unsigned                 pt_frame  [PAGE_COUNT];
  int unsigned                 free_frame;
  logic [tlbpt_pkg::CNT_W-1:0] hit_cnt;
  logic [tlbpt_pkg::CNT_W-1:0] miss_cnt;
  logic [tlbpt_pkg::CNT_W-1:0] fault_cnt;
  xlat_t                       pending_xlats [$];

  task automatic translate_address(input logic [tlbpt_pkg::ADDR_W-1:0] va,
                                   output xlat_t res);
    int unsigned page;
    int unsigned offs;
    int unsigned frm;
    int unsigned slot;
    bit          hit;
    bit          fault;
    offs  = 32'(va) & ((1 << OFFSET_BITS) - 1);
    page  = (32'(va) >> OFFSET_BITS) % PAGE_COUNT;
    frm   = 0;
    hit   = 1'b0;
    fault = 1'b0;
    for (int i = 0; i < tlb_used; i++) begin
      if (!hit && tlb_page[i] == page) begin
        frm = tlb_frame[i];
        hit = 1'b1;
      end
    end
    if (hit) begin
      if (hit_cnt != '1) hit_cnt++;
    end else begin
      // A page fault is also a TLB miss.
      if (miss_cnt != '1) miss_cnt++;
      if (pt_valid[page]) begin
        frm = pt_frame[page];
      end else begin
        fault = 1'b1;
        if (fault_cnt != '1) fault_cnt++;
        frm = free_frame % FRAME_COUNT;
        pt_valid[page] = 1'b1;
        pt_frame[page] = frm;
        free_frame = (frm + 1) % FRAME_COUNT;
      end
      // Free slots fill first, then the oldest entry is replaced.
      if (tlb_used < TLB_ENTRIES) begin
        slot = tlb_used;
        tlb_used++;
      end else begin
        slot = tlb_victim;
        tlb_victim = (tlb_victim + 1) % TLB_ENTRIES;
      end
      tlb_page[slot]  = page;
      tlb_frame[slot] = frm;
    end
    res.phys_addr   = tlbpt_pkg::ADDR_W'((frm << OFFSET_BITS) | offs);
    res.tlb_hit     = hit;
    res.page_fault  = fault;
    res.hit_total   = hit_cnt;
    res.miss_total  = miss_cnt;
    res.fault_total = fault_cnt;
  endtask

  task automatic check_field(input string fname,
                             input logic [tlbpt_pkg::CNT_W-1:0] exp_v,
                             input logic [tlbpt_pkg::CNT_W-1:0] act_v);
    if (act_v !== exp_v) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, fname, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    xlat_t exp_r;
    xlat_t new_r;
    if (!rst_n) begin
      tlb_used   = 0;
      tlb_victim = 0;
      free_frame = 0;
      hit_cnt    = '0;
      miss_cnt   = '0;
      fault_cnt  = '0;
      mismatches = 0;
      foreach (pt_valid[i]) pt_valid[i] = 1'b0;
      pending_xlats.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (pending_xlats.size() == 0) begin
          mismatches++;
          $display("%0t: result transfer with no translation pending, got %0h",
                   $time, out_tdata);
        end else begin
          exp_r = pending_xlats.pop_front();
          check_field("physical_address", tlbpt_pkg::CNT_W'(exp_r.phys_addr),
                      tlbpt_pkg::CNT_W'(out_tdata[tlbpt_pkg::ADDR_W-1:0]));
          check_field("tlb_hit", tlbpt_pkg::CNT_W'(exp_r.tlb_hit),
                      tlbpt_pkg::CNT_W'(out_tdata[tlbpt_pkg::OUT_HIT_BIT]));
          check_field("page_fault", tlbpt_pkg::CNT_W'(exp_r.page_fault),
                      tlbpt_pkg::CNT_W'(out_tdata[tlbpt_pkg::OUT_FAULT_BIT]));
          check_field("hit_total", exp_r.hit_total,
                      out_tdata[tlbpt_pkg::OUT_HTOT_LSB +: tlbpt_pkg::CNT_W]);
          check_field("miss_total", exp_r.miss_total,
                      out_tdata[tlbpt_pkg::OUT_MTOT_LSB +: tlbpt_pkg::CNT_W]);
          check_field("fault_total", exp_r.fault_total,
                      out_tdata[tlbpt_pkg::OUT_FTOT_LSB +: tlbpt_pkg::CNT_W]);
          check_field("padding", '0, tlbpt_pkg::CNT_W'(
                      out_tdata[tlbpt_pkg::OUT_DATA_W-1:tlbpt_pkg::OUT_USED_W]));
        end
      end
      if (in_tvalid && in_tready) begin
        translate_address(in_tdata[tlbpt_pkg::ADDR_W-1:0], new_r);
        pending_xlats.push_back(new_r);
      end
    end
    outstanding = pending_xlats.size();
  end

endmodule

>>> sim/tlb_page_table_translator_tb.sv
// ----------------------------------------------------------------------------
// TLB page table translator testbench
// Drives virtual addresses into the translator: a directed opening over the
// address extremes, TLB hits, FIFO eviction and page table hits, then random
// addresses drawn mostly from hot and warm page sets. Both sides idle at
// random, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tlb_page_table_translator_tb;

  localparam int unsigned RANDOM_ADDRS = 1600;
  localparam int unsigned HOT_PAGES    = 12;
  localparam int unsigned WARM_PAGES   = 24;

  logic                             clk = 1'b0;
  logic                             rst_n;
  logic                             in_tvalid;
  logic                             in_tready;
  logic [tlbpt_pkg::IN_DATA_W-1:0]  in_tdata;
  logic                             out_tvalid;
  logic                             out_tready;
  logic [tlbpt_pkg::OUT_DATA_W-1:0] out_tdata;
  int unsigned                      mismatches;
  int unsigned                      outstanding;
  bit                               gaps_on;
  bit                               hold_req;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  tlb_page_table_translator DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  tlb_translation_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // Offers one address and returns at the falling edge after its transfer.
  task automatic send_translation(input logic [tlbpt_pkg::ADDR_W-1:0] va);
    while (gaps_on && $urandom_range(99) < 18) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = va;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // Result side: random back-pressure plus one long hold-off on request.
  initial begin
    int unsigned hold_left;
    bit          hold_done;
    out_tready = 1'b0;
    hold_left  = 0;
    hold_done  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_left = 300;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        out_tready = 1'b0;
        hold_left--;
      end else begin
        out_tready = !(gaps_on && $urandom_range(99) < 18);
      end
    end
  end

  initial begin
    logic [7:0] hot_set  [HOT_PAGES];
    logic [7:0] warm_set [WARM_PAGES];
    logic [7:0] pg;
    int unsigned pick;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    gaps_on   = 1'b1;
    hold_req  = 1'b0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // Extremes, then a hit on each of the first pages.
    send_translation(16'h0000);
    send_translation(16'hFFFF);
    send_translation(16'h00FF);
    send_translation(16'hFF00);
    send_translation(16'h1234);
    send_translation(16'h12AB);
    // Sixteen new pages fill the TLB and push out the three oldest entries.
    for (int p = 1; p <= 16; p++) send_translation({8'(p), ~8'(p)});
    // Evicted pages now resolve through the page table without a fault.
    send_translation(16'h0080);
    send_translation(16'hFF7F);
    send_translation(16'h1200);

    hold_req = 1'b1;
    foreach (hot_set[i]) hot_set[i] = 8'($urandom_range(255));
    foreach (warm_set[i]) warm_set[i] = 8'($urandom_range(255));
    for (int n = 0; n < RANDOM_ADDRS; n++) begin
      gaps_on = !(n >= 700 && n < 1000);
      // Slowly drift the working sets so the TLB keeps turning over.
      if (n % 50 == 49) hot_set[$urandom_range(HOT_PAGES - 1)] = 8'($urandom_range(255));
      if (n % 20 == 19) warm_set[$urandom_range(WARM_PAGES - 1)] = 8'($urandom_range(255));
      pick = $urandom_range(99);
      if (pick < 55) pg = hot_set[$urandom_range(HOT_PAGES - 1)];
      else if (pick < 75) pg = warm_set[$urandom_range(WARM_PAGES - 1)];
      else pg = 8'($urandom_range(255));
      send_translation({pg, 8'($urandom_range(255))});
    end
    in_tvalid = 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #4800000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
